// ===== hw/rtl/bbr_pkg.sv =====
// Shared types, constants and helper functions of the 3x3 box blur block.
package bbr_pkg;

  localparam int unsigned CH_W = 8;
  localparam int unsigned PIX_W = 3 * CH_W;
  localparam int unsigned SUM_W = 12;

  localparam int unsigned DEF_MAX_WIDTH = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;

  localparam int unsigned IMAGE_WIDTH_W = 11;
  localparam int unsigned IMAGE_HEIGHT_W = 13;
  localparam int unsigned IMAGE_WIDTH_RESET = 640;
  localparam int unsigned IMAGE_HEIGHT_RESET = 480;

  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

  // Reciprocals for the divisions by three and by nine, with their shifts.
  localparam logic [11:0] RECIP_3 = 12'd2731;
  localparam int unsigned SHIFT_3 = 13;
  localparam logic [11:0] RECIP_9 = 12'd1821;
  localparam int unsigned SHIFT_9 = 14;

  typedef enum logic [2:0] {
    CNT_1 = 3'd0,
    CNT_2 = 3'd1,
    CNT_3 = 3'd2,
    CNT_4 = 3'd3,
    CNT_6 = 3'd4,
    CNT_9 = 3'd5
  } cnt_e;

  // Control and payload of an item that has passed the input stage.
  typedef struct packed {
    logic             emit;
    logic             bank;
    logic             left;
    logic             right;
    logic             top;
    logic             bottom;
    logic             last;
    logic [PIX_W-1:0] pix;
  } stage1_t;

  // Number of contributing pixels from the number of columns and rows.
  function automatic cnt_e count_code(logic [1:0] ncol, logic [1:0] nrow);
    cnt_e c;
    case ({ncol, nrow})
      4'b0101: c = CNT_1;
      4'b0110: c = CNT_2;
      4'b0111: c = CNT_3;
      4'b1001: c = CNT_2;
      4'b1010: c = CNT_4;
      4'b1011: c = CNT_6;
      4'b1101: c = CNT_3;
      4'b1110: c = CNT_6;
      4'b1111: c = CNT_9;
      default: c = CNT_1;
    endcase
    return c;
  endfunction

  // Truncated mean: one small multiply by a reciprocal for 3, 6 and 9.
  function automatic logic [CH_W-1:0] mean_div(logic [SUM_W-1:0] s, cnt_e c);
    logic [SUM_W-1:0] opnd;
    logic [11:0]      recip;
    logic [23:0]      prod;
    logic [CH_W-1:0]  res;
    opnd  = (c == CNT_6) ? (s >> 1) : s;
    recip = (c == CNT_9) ? RECIP_9 : RECIP_3;
    prod  = 24'(opnd) * 24'(recip);
    case (c)
      CNT_1:   res = s[CH_W-1:0];
      CNT_2:   res = s[CH_W:1];
      CNT_4:   res = s[CH_W+1:2];
      CNT_3,
      CNT_6:   res = prod[SHIFT_3 +: CH_W];
      CNT_9:   res = prod[SHIFT_9 +: CH_W];
      default: res = s[CH_W-1:0];
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/bbr_if.sv =====
// Valid/ready channel interfaces for the pixel input and the result output.
interface bbr_in_if;
  logic                     valid;
  logic                     ready;
  logic                     flush;
  logic [bbr_pkg::CH_W-1:0] in_blue;
  logic [bbr_pkg::CH_W-1:0] in_green;
  logic [bbr_pkg::CH_W-1:0] in_red;

  modport source (output valid, output flush, output in_blue, output in_green,
                  output in_red, input ready);
  modport sink (input valid, input flush, input in_blue, input in_green,
                input in_red, output ready);
endinterface

interface bbr_out_if;
  logic                     valid;
  logic                     ready;
  logic [bbr_pkg::CH_W-1:0] out_blue;
  logic [bbr_pkg::CH_W-1:0] out_green;
  logic [bbr_pkg::CH_W-1:0] out_red;
  logic                     frame_last;

  modport source (output valid, output out_blue, output out_green, output out_red,
                  output frame_last, input ready);
  modport sink (input valid, input out_blue, input out_green, input out_red,
                input frame_last, output ready);
endinterface

// ===== hw/rtl/bbr_ram.sv =====
// Generic single-clock RAM with one write port and a registered read port.
module bbr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read and a write at the same address return the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/box_blur_3x3_rgb_core.sv =====
// 3x3 box blur over an RGB raster stream: line banks, window and mean pipeline.
// Throughput: one item per clock cycle, limited only by back pressure at the output.
// Results pass stage 1, stage 2 and the output register after the completing item is taken;
// the result for pixel q is completed by the item W + 1 positions later (pixel or flush).
// Reset clears the counters, the window and the pipeline and sets width 640, height 480.
// The line banks are not cleared: entries not written in the current frame are masked.
module box_blur_3x3_rgb_core #(
  parameter int unsigned MAX_WIDTH  = bbr_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bbr_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bbr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bbr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bbr_in_if.sink                         pix_i,
  bbr_out_if.source                      pix_o
);

  // Column index, effective width, row counter and output row widths.
  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned ORW = $clog2(MAX_HEIGHT);
  localparam int unsigned PW  = bbr_pkg::PIX_W;
  localparam int unsigned CHW = bbr_pkg::CH_W;
  localparam int unsigned SW  = bbr_pkg::SUM_W;

  localparam int unsigned W_RESET = (bbr_pkg::IMAGE_WIDTH_RESET > MAX_WIDTH) ?
                                    MAX_WIDTH : bbr_pkg::IMAGE_WIDTH_RESET;
  localparam int unsigned H_RESET = (bbr_pkg::IMAGE_HEIGHT_RESET > MAX_HEIGHT) ?
                                    MAX_HEIGHT : bbr_pkg::IMAGE_HEIGHT_RESET;

  // Effective frame size, already clamped to the range 1..MAX when written.
  logic [WW-1:0]  w_q;
  logic [HW-1:0]  h_q;
  logic [WW-1:0]  w_m1;
  logic [HW-1:0]  h_m1;

  // Input position (column, row) and output position of the next result.
  logic [CW-1:0]  in_col_q, in_col_d;
  logic [HW-1:0]  in_row_q, in_row_d;
  logic [CW-1:0]  out_col_q, out_col_d;
  logic [ORW-1:0] out_row_q, out_row_d;

  // Pipeline: stage 1 waits for the line bank read, stage 2 holds the sums,
  // then the output register.
  logic                 s1_valid_q;
  bbr_pkg::stage1_t     s1_q, s1_d;
  logic                 s2_valid_q;
  logic [SW-1:0]        sum_q [3];
  logic [SW-1:0]        sum_d [3];
  bbr_pkg::cnt_e        cnt_q, cnt_d;
  logic                 last2_q;
  logic                 out_valid_q;
  logic [CHW-1:0]       out_b_q, out_g_q, out_r_q;
  logic                 out_last_q;

  logic [PW-1:0] win_q [9];
  logic [PW-1:0] win_d [9];

  logic out_en, s2_en, s1_en, accept;
  logic row_done, step, emit, col_last, frame_last;
  logic [PW-1:0] pix;
  logic [PW-1:0] bank0_rd, bank1_rd, upper_rd, middle_rd;
  logic [10:0]   cfg_w_raw;
  logic [12:0]   cfg_h_raw;
  logic [WW-1:0] cfg_w_eff;
  logic [HW-1:0] cfg_h_eff;
  logic          cfg_w_wr, cfg_h_wr;

  // ---------------------------------------------------------------------------
  // Configuration: a zero dimension counts as one, a large one saturates.
  // A write to either register restarts the frame; other indexes are ignored.
  // ---------------------------------------------------------------------------
  assign cfg_w_raw = cfg_data_i[bbr_pkg::IMAGE_WIDTH_W-1:0];
  assign cfg_h_raw = cfg_data_i[bbr_pkg::IMAGE_HEIGHT_W-1:0];
  assign cfg_w_wr  = cfg_we_i && (cfg_idx_i == bbr_pkg::REG_IMAGE_WIDTH);
  assign cfg_h_wr  = cfg_we_i && (cfg_idx_i == bbr_pkg::REG_IMAGE_HEIGHT);

  always_comb begin
    if (cfg_w_raw == 11'd0) begin
      cfg_w_eff = WW'(1);
    end else if (32'(cfg_w_raw) > MAX_WIDTH) begin
      cfg_w_eff = WW'(MAX_WIDTH);
    end else begin
      cfg_w_eff = WW'(cfg_w_raw);
    end
    if (cfg_h_raw == 13'd0) begin
      cfg_h_eff = HW'(1);
    end else if (32'(cfg_h_raw) > MAX_HEIGHT) begin
      cfg_h_eff = HW'(MAX_HEIGHT);
    end else begin
      cfg_h_eff = HW'(cfg_h_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= WW'(W_RESET);
      h_q <= HW'(H_RESET);
    end else begin
      if (cfg_w_wr) begin
        w_q <= cfg_w_eff;
      end
      if (cfg_h_wr) begin
        h_q <= cfg_h_eff;
      end
    end
  end

  assign w_m1 = w_q - WW'(1);
  assign h_m1 = h_q - HW'(1);

  // ---------------------------------------------------------------------------
  // Handshake. Each stage moves when the stage after it is empty or moving,
  // so items are still taken while a result waits at the output, until stage 1 and stage 2 are full.
  // ---------------------------------------------------------------------------
  assign out_en      = !out_valid_q || pix_o.ready;
  assign s2_en       = !s2_valid_q || out_en;
  assign s1_en       = !s1_valid_q || s2_en;
  assign pix_i.ready = s1_en;
  assign accept      = pix_i.valid && s1_en;

  // ---------------------------------------------------------------------------
  // Input stage. The row counter reaching the height marks the last pixel as
  // taken: from then on pixels are dropped and flush items drain the frame;
  // before that, flush items are dropped. A result is due once the input
  // position has passed one row plus one pixel. The output position counters
  // give the edge masks directly, so no position arithmetic is needed.
  // ---------------------------------------------------------------------------
  assign row_done   = (in_row_q >= h_q);
  assign step       = accept && (pix_i.flush == row_done);
  assign emit       = (in_row_q >= HW'(2)) || ((in_row_q == HW'(1)) && (in_col_q != '0));
  assign col_last   = (WW'(in_col_q) == w_m1);
  assign frame_last = (HW'(out_row_q) == h_m1) && (WW'(out_col_q) == w_m1);
  assign pix        = pix_i.flush ? '0 : {pix_i.in_red, pix_i.in_green, pix_i.in_blue};

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_w_wr || cfg_h_wr) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (step) begin
      if (col_last) begin
        in_col_d = '0;
        in_row_d = in_row_q + HW'(1);
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
      if (emit) begin
        if (frame_last) begin
          // Final result of the frame: the next pixel starts a new one.
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (WW'(out_col_q) == w_m1) begin
          out_col_d = '0;
          out_row_d = out_row_q + ORW'(1);
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  always_comb begin
    s1_d.emit   = emit;
    s1_d.bank   = in_row_q[0];
    s1_d.left   = (out_col_q == '0);
    s1_d.right  = (WW'(out_col_q) == w_m1);
    s1_d.top    = (out_row_q == '0);
    s1_d.bottom = (HW'(out_row_q) == h_m1);
    s1_d.last   = frame_last;
    s1_d.pix    = pix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line banks. Rows alternate between two banks by row parity: the bank of
  // the current row parity holds the row two above and is overwritten in
  // place, the other bank holds the row just above. Read and write share the
  // column address, and a same-address read returns the old entry.
  // ---------------------------------------------------------------------------
  bbr_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (step && !in_row_q[0]),
    .waddr_i (in_col_q),
    .wdata_i (pix),
    .re_i    (step),
    .raddr_i (in_col_q),
    .rdata_o (bank0_rd)
  );

  bbr_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (step && in_row_q[0]),
    .waddr_i (in_col_q),
    .wdata_i (pix),
    .re_i    (step),
    .raddr_i (in_col_q),
    .rdata_o (bank1_rd)
  );

  assign upper_rd  = s1_q.bank ? bank1_rd : bank0_rd;
  assign middle_rd = s1_q.bank ? bank0_rd : bank1_rd;

  // ---------------------------------------------------------------------------
  // Window and sums. The window holds three columns (left, middle, right) of
  // three rows (above, center, below); entry k*3+i is column k, row i. The
  // new column enters on the right and the masked sums are taken over the
  // shifted window.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      win_d[j] = win_q[j+3];
    end
    win_d[6] = upper_rd;
    win_d[7] = middle_rd;
    win_d[8] = s1_q.pix;
  end

  always_comb begin
    logic use_tap;
    for (int ch = 0; ch < 3; ch++) begin
      sum_d[ch] = '0;
    end
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        use_tap = !((k == 0) && s1_q.left) && !((k == 2) && s1_q.right) &&
                  !((i == 0) && s1_q.top) && !((i == 2) && s1_q.bottom);
        for (int ch = 0; ch < 3; ch++) begin
          if (use_tap) begin
            sum_d[ch] = sum_d[ch] + SW'(win_d[k*3+i][ch*CHW +: CHW]);
          end
        end
      end
    end
  end

  assign cnt_d = bbr_pkg::count_code(2'd3 - {1'b0, s1_q.left} - {1'b0, s1_q.right},
                                     2'd3 - {1'b0, s1_q.top} - {1'b0, s1_q.bottom});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < 9; j++) begin
        win_q[j] <= '0;
      end
      s2_valid_q <= 1'b0;
    end else begin
      if (s2_en) begin
        s2_valid_q <= s1_valid_q && s1_q.emit;
        if (s1_valid_q) begin
          for (int j = 0; j < 9; j++) begin
            win_q[j] <= win_d[j];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q && s1_q.emit) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum_q[ch] <= sum_d[ch];
      end
      cnt_q   <= cnt_d;
      last2_q <= s1_q.last;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: divide each sum by the pixel count and hold the result
  // until it is taken.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s2_valid_q) begin
      out_b_q    <= bbr_pkg::mean_div(sum_q[0], cnt_q);
      out_g_q    <= bbr_pkg::mean_div(sum_q[1], cnt_q);
      out_r_q    <= bbr_pkg::mean_div(sum_q[2], cnt_q);
      out_last_q <= last2_q;
    end
  end

  assign pix_o.valid      = out_valid_q;
  assign pix_o.out_blue   = out_b_q;
  assign pix_o.out_green  = out_g_q;
  assign pix_o.out_red    = out_r_q;
  assign pix_o.frame_last = out_last_q;

endmodule
